// ----- src/uwb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the word boundary finder.
// No dependencies; used by the top level.

package uwb_pkg;

	// Item kinds on the input channel.
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_CHAR  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// Word boundary classes of a code point.
	localparam logic [4:0] C_OTHER     = 5'd0;
	localparam logic [4:0] C_CR        = 5'd1;
	localparam logic [4:0] C_LF        = 5'd2;
	localparam logic [4:0] C_NEWLINE   = 5'd3;
	localparam logic [4:0] C_EXTEND    = 5'd4;
	localparam logic [4:0] C_ZWJ       = 5'd5;
	localparam logic [4:0] C_RI        = 5'd6;
	localparam logic [4:0] C_FORMAT    = 5'd7;
	localparam logic [4:0] C_KATAKANA  = 5'd8;
	localparam logic [4:0] C_HEBREW    = 5'd9;
	localparam logic [4:0] C_ALETTER   = 5'd10;
	localparam logic [4:0] C_SQUOTE    = 5'd11;
	localparam logic [4:0] C_DQUOTE    = 5'd12;
	localparam logic [4:0] C_MIDNUMLET = 5'd13;
	localparam logic [4:0] C_MIDLETTER = 5'd14;
	localparam logic [4:0] C_MIDNUM    = 5'd15;
	localparam logic [4:0] C_NUMERIC   = 5'd16;
	localparam logic [4:0] C_EXTNUMLET = 5'd17;
	localparam logic [4:0] C_WSEGSPACE = 5'd18;
	localparam logic [4:0] C_NONE      = 5'd31;

	typedef enum logic [1:0] {
		V_KEEP  = 2'd0,
		V_BREAK = 2'd1,
		V_LOOK  = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		NEED_NONE     = 2'd0,
		NEED_AHLETTER = 2'd1,
		NEED_HEBREW   = 2'd2,
		NEED_NUMERIC  = 2'd3
	} need_t;

	typedef struct packed {
		verdict_t verdict;
		need_t    needs;
	} decision_t;

endpackage

// ----- src/unicode_word_boundary_finder.sv -----
`timescale 1ns / 1ps
// Word boundary finder after the segmentation rules of Unicode Annex 29.
// Depends on uwb_pkg for class codes, item kinds and the decision type.

// The block accepts one classified code point per cycle while item_stall is
// low. An accepted item is held in an input register, decided there against
// the context registers, and its zero, one or two boundaries are written
// into a four-entry result queue, from which the first boundary can be taken.
// The result port moves one boundary per cycle while boundary_stall is low,
// so the sustained rate is one item per cycle as long as items average at
// most one boundary each; the input stalls while the queue cannot take two
// more results. A boundary after a letter or digit followed by a mid-word
// punctuation class is held back until the next non-ignorable code point or
// the end of text decides it, and then comes out ahead of that item's own
// boundary.

module unicode_word_boundary_finder #(
	parameter int POSITION_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic [1:0]               kind,
	input  logic [4:0]               wb_class,
	input  logic                     ext_pict,
	input  logic [POSITION_BITS-1:0] position,
	output logic                     boundary_valid,
	input  logic                     boundary_stall,
	output logic [POSITION_BITS-1:0] boundary_position,
	output logic                     last_of_run
);

	localparam int DEPTH    = 4;
	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	// Input register.
	logic                     valid_s1;
	logic [1:0]               kind_s1;
	logic [4:0]               class_s1;
	logic                     pict_s1;
	logic [POSITION_BITS-1:0] pos_s1;

	// Context registers.
	logic [4:0]               fold_prev_q;
	logic [4:0]               fold_pprev_q;
	logic [4:0]               raw_prev_q;
	logic                     prev_zwj_q;
	logic                     ri_odd_q;
	logic                     seen_q;
	logic [POSITION_BITS-1:0] last_bnd_q;
	logic                     pend_valid_q;
	logic [POSITION_BITS-1:0] pend_pos_q;
	uwb_pkg::need_t           pend_needs_q;

	// Result queue.
	logic [POSITION_BITS-1:0] qpos_q  [DEPTH];
	logic                     qlast_q [DEPTH];
	logic [PTR_BITS-1:0]      wr_ptr_q;
	logic [PTR_BITS-1:0]      rd_ptr_q;
	logic [CNT_BITS-1:0]      count_q;

	logic accept;
	logic advance;
	logic pop;

	// Next-state and result logic.
	logic [4:0]               cls;
	uwb_pkg::decision_t       dec;
	logic [1:0]               n_res;
	logic [POSITION_BITS-1:0] res0_pos;
	logic [POSITION_BITS-1:0] res1_pos;
	logic [4:0]               fold_prev_d;
	logic [4:0]               fold_pprev_d;
	logic [4:0]               raw_prev_d;
	logic                     prev_zwj_d;
	logic                     ri_odd_d;
	logic                     seen_d;
	logic [POSITION_BITS-1:0] last_bnd_d;
	logic                     pend_valid_d;
	logic [POSITION_BITS-1:0] pend_pos_d;
	uwb_pkg::need_t           pend_needs_d;
	logic                     pend_breaks;
	logic                     brk;
	logic [POSITION_BITS-1:0] mid_bnd;

	function automatic logic is_ah(input logic [4:0] v);
		return (v == uwb_pkg::C_ALETTER) || (v == uwb_pkg::C_HEBREW);
	endfunction

	function automatic logic is_mnlq(input logic [4:0] v);
		return (v == uwb_pkg::C_MIDNUMLET) || (v == uwb_pkg::C_SQUOTE);
	endfunction

	function automatic logic is_forcing(input logic [4:0] v);
		return (v == uwb_pkg::C_NEWLINE) || (v == uwb_pkg::C_CR) || (v == uwb_pkg::C_LF);
	endfunction

	function automatic logic is_ign(input logic [4:0] v);
		return (v == uwb_pkg::C_EXTEND) || (v == uwb_pkg::C_FORMAT) ||
			(v == uwb_pkg::C_ZWJ);
	endfunction

	// Rule chain for the gap between the previous character and cur.
	function automatic uwb_pkg::decision_t decide(
		input logic [4:0] cur,
		input logic       ep,
		input logic [4:0] p,
		input logic [4:0] pp,
		input logic [4:0] r,
		input logic       zwj,
		input logic       odd
	);
		uwb_pkg::decision_t d;
		logic pah;
		logic cah;
		pah = is_ah(p);
		cah = is_ah(cur);
		d.verdict = uwb_pkg::V_KEEP;
		d.needs = uwb_pkg::NEED_NONE;
		if (r == uwb_pkg::C_CR && cur == uwb_pkg::C_LF) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (is_forcing(r) || is_forcing(cur)) begin
			d.verdict = uwb_pkg::V_BREAK;
		end else if (zwj && ep) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (r == uwb_pkg::C_WSEGSPACE && cur == uwb_pkg::C_WSEGSPACE) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (is_ign(cur)) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (pah && cah) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (is_ah(pp) && (p == uwb_pkg::C_MIDLETTER || is_mnlq(p)) && cah) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (p == uwb_pkg::C_HEBREW && cur == uwb_pkg::C_SQUOTE) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (pp == uwb_pkg::C_HEBREW && p == uwb_pkg::C_DQUOTE &&
			cur == uwb_pkg::C_HEBREW) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (p == uwb_pkg::C_NUMERIC && cur == uwb_pkg::C_NUMERIC) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (pah && cur == uwb_pkg::C_NUMERIC) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (p == uwb_pkg::C_NUMERIC && cah) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (pp == uwb_pkg::C_NUMERIC && (p == uwb_pkg::C_MIDNUM || is_mnlq(p)) &&
			cur == uwb_pkg::C_NUMERIC) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (p == uwb_pkg::C_KATAKANA && cur == uwb_pkg::C_KATAKANA) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if ((pah || p == uwb_pkg::C_NUMERIC || p == uwb_pkg::C_KATAKANA ||
			p == uwb_pkg::C_EXTNUMLET) && cur == uwb_pkg::C_EXTNUMLET) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (p == uwb_pkg::C_EXTNUMLET && (cah || cur == uwb_pkg::C_NUMERIC ||
			cur == uwb_pkg::C_KATAKANA)) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (p == uwb_pkg::C_RI && cur == uwb_pkg::C_RI && odd) begin
			d.verdict = uwb_pkg::V_KEEP;
		end else if (pah && (cur == uwb_pkg::C_MIDLETTER || is_mnlq(cur))) begin
			d.verdict = uwb_pkg::V_LOOK;
			d.needs = uwb_pkg::NEED_AHLETTER;
		end else if (p == uwb_pkg::C_HEBREW && cur == uwb_pkg::C_DQUOTE) begin
			d.verdict = uwb_pkg::V_LOOK;
			d.needs = uwb_pkg::NEED_HEBREW;
		end else if (p == uwb_pkg::C_NUMERIC && (cur == uwb_pkg::C_MIDNUM || is_mnlq(cur))) begin
			d.verdict = uwb_pkg::V_LOOK;
			d.needs = uwb_pkg::NEED_NUMERIC;
		end else begin
			d.verdict = uwb_pkg::V_BREAK;
		end
		return d;
	endfunction

	// Handshakes. Room for two results lets the held item always advance.
	assign advance    = valid_s1 && (count_q <= CNT_BITS'(DEPTH - 2));
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign pop        = boundary_valid && !boundary_stall;

	assign boundary_valid    = (count_q != '0);
	assign boundary_position = qpos_q[rd_ptr_q];
	assign last_of_run       = qlast_q[rd_ptr_q];

	always_comb begin
		cls = (class_s1 > uwb_pkg::C_WSEGSPACE) ? uwb_pkg::C_OTHER : class_s1;
		dec = decide(cls, pict_s1, fold_prev_q, fold_pprev_q, raw_prev_q, prev_zwj_q,
			ri_odd_q);

		fold_prev_d  = fold_prev_q;
		fold_pprev_d = fold_pprev_q;
		raw_prev_d   = raw_prev_q;
		prev_zwj_d   = prev_zwj_q;
		ri_odd_d     = ri_odd_q;
		seen_d       = seen_q;
		last_bnd_d   = last_bnd_q;
		pend_valid_d = pend_valid_q;
		pend_pos_d   = pend_pos_q;
		pend_needs_d = pend_needs_q;
		n_res        = 2'd0;
		res0_pos     = pos_s1;
		res1_pos     = pos_s1;
		brk          = 1'b0;
		mid_bnd      = last_bnd_q;

		pend_breaks = !((pend_needs_q == uwb_pkg::NEED_AHLETTER && is_ah(cls)) ||
			(pend_needs_q == uwb_pkg::NEED_HEBREW && cls == uwb_pkg::C_HEBREW) ||
			(pend_needs_q == uwb_pkg::NEED_NUMERIC && cls == uwb_pkg::C_NUMERIC));

		case (kind_s1)
			uwb_pkg::KIND_START: begin
				fold_prev_d  = uwb_pkg::C_NONE;
				fold_pprev_d = uwb_pkg::C_NONE;
				raw_prev_d   = uwb_pkg::C_NONE;
				prev_zwj_d   = 1'b0;
				ri_odd_d     = 1'b0;
				seen_d       = 1'b0;
				pend_valid_d = 1'b0;
				pend_pos_d   = '0;
				pend_needs_d = uwb_pkg::NEED_NONE;
				last_bnd_d   = '0;
				n_res        = 2'd1;
				res0_pos     = '0;
			end
			uwb_pkg::KIND_CHAR: begin
				// A held candidate resolves first, so its boundary comes out first.
				if (pend_valid_q && !is_ign(cls)) begin
					pend_valid_d = 1'b0;
					if (pend_breaks) begin
						n_res    = 2'd1;
						res0_pos = pend_pos_q;
						last_bnd_d = pend_pos_q;
					end
				end
				if (seen_q) begin
					if (dec.verdict == uwb_pkg::V_BREAK) begin
						brk = 1'b1;
						if (n_res == 2'd1) begin
							res1_pos = pos_s1;
						end else begin
							res0_pos = pos_s1;
						end
						n_res = n_res + 2'd1;
						last_bnd_d = pos_s1;
					end else if (dec.verdict == uwb_pkg::V_LOOK) begin
						pend_valid_d = 1'b1;
						pend_pos_d   = pos_s1;
						pend_needs_d = dec.needs;
					end
				end
				// Extend, Format and ZWJ fold into the character before them.
				if (!(is_ign(cls) && !brk && fold_prev_q != uwb_pkg::C_NONE)) begin
					fold_pprev_d = fold_prev_q;
					fold_prev_d  = cls;
					ri_odd_d     = (cls == uwb_pkg::C_RI) ? !ri_odd_q : 1'b0;
				end
				raw_prev_d = cls;
				prev_zwj_d = (cls == uwb_pkg::C_ZWJ);
				seen_d     = 1'b1;
			end
			uwb_pkg::KIND_END: begin
				if (pend_valid_q) begin
					n_res    = 2'd1;
					res0_pos = pend_pos_q;
					mid_bnd  = pend_pos_q;
				end
				last_bnd_d = mid_bnd;
				if (mid_bnd < pos_s1) begin
					if (n_res == 2'd1) begin
						res1_pos = pos_s1;
					end else begin
						res0_pos = pos_s1;
					end
					n_res = n_res + 2'd1;
					last_bnd_d = pos_s1;
				end
				fold_prev_d  = uwb_pkg::C_NONE;
				fold_pprev_d = uwb_pkg::C_NONE;
				raw_prev_d   = uwb_pkg::C_NONE;
				prev_zwj_d   = 1'b0;
				ri_odd_d     = 1'b0;
				seen_d       = 1'b0;
				pend_valid_d = 1'b0;
				pend_pos_d   = '0;
				pend_needs_d = uwb_pkg::NEED_NONE;
			end
			default: begin
				n_res = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			class_s1 <= wb_class;
			pict_s1  <= ext_pict;
			pos_s1   <= position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_prev_q  <= uwb_pkg::C_NONE;
			fold_pprev_q <= uwb_pkg::C_NONE;
			raw_prev_q   <= uwb_pkg::C_NONE;
			prev_zwj_q   <= 1'b0;
			ri_odd_q     <= 1'b0;
			seen_q       <= 1'b0;
			last_bnd_q   <= '0;
			pend_valid_q <= 1'b0;
			pend_pos_q   <= '0;
			pend_needs_q <= uwb_pkg::NEED_NONE;
		end else if (advance) begin
			fold_prev_q  <= fold_prev_d;
			fold_pprev_q <= fold_pprev_d;
			raw_prev_q   <= raw_prev_d;
			prev_zwj_q   <= prev_zwj_d;
			ri_odd_q     <= ri_odd_d;
			seen_q       <= seen_d;
			last_bnd_q   <= last_bnd_d;
			pend_valid_q <= pend_valid_d;
			pend_pos_q   <= pend_pos_d;
			pend_needs_q <= pend_needs_d;
		end
	end

	// Result queue: up to two writes and one read per cycle.
	always_ff @(posedge clk) begin
		if (advance && n_res != 2'd0) begin
			qpos_q[wr_ptr_q]  <= res0_pos;
			qlast_q[wr_ptr_q] <= (n_res == 2'd1);
			if (n_res == 2'd2) begin
				qpos_q[wr_ptr_q + PTR_BITS'(1)]  <= res1_pos;
				qlast_q[wr_ptr_q + PTR_BITS'(1)] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			count_q <= count_q + (advance ? CNT_BITS'(n_res) : CNT_BITS'(0)) -
				(pop ? CNT_BITS'(1) : CNT_BITS'(0));
		end
	end

endmodule

// ----- src/uwb_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the word boundary finder, bound to the top level.
// Depends only on the top level's ports.

module uwb_checker #(
	parameter int POSITION_BITS = 24
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     item_valid,
	input logic                     item_stall,
	input logic                     boundary_valid,
	input logic                     boundary_stall,
	input logic [POSITION_BITS-1:0] boundary_position,
	input logic                     last_of_run
);

	// A result that is offered stays offered until its transfer.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		boundary_valid && boundary_stall |=> boundary_valid)
		else $error("boundary_valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		boundary_valid && boundary_stall |=>
		$stable(boundary_position) && $stable(last_of_run))
		else $error("boundary payload changed while stalled");

	// With the result queue empty the input side never has to wait.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!boundary_valid |-> !item_stall)
		else $error("input stalled with no result pending");

	// A cycle without an offered item leaves the input register free.
	a_idle_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		!item_valid && !item_stall |=> !item_stall)
		else $error("input stalled after an idle cycle");

	// Both results of one item are queued together, so the second follows at once.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		boundary_valid && !boundary_stall && !last_of_run |=> boundary_valid)
		else $error("second boundary of an item missing");

endmodule

bind unicode_word_boundary_finder uwb_checker #(
	.POSITION_BITS(POSITION_BITS)
) u_uwb_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item_valid),
	.item_stall        (item_stall),
	.boundary_valid    (boundary_valid),
	.boundary_stall    (boundary_stall),
	.boundary_position (boundary_position),
	.last_of_run       (last_of_run)
);
